### rtl/fbx_pkg.sv
// ----------------------------------------------------------------------------
// fbx_pkg
// Shared types and constants of the four-band crossover magnitude pipeline.
// ----------------------------------------------------------------------------
package fbx_pkg;

  // cordic datapath word, Q2.30 with headroom
  localparam int XW = 34;
  typedef logic signed [XW-1:0] cval_t;

  // per-item sideband traveling along the pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic in_range;
  } meta_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FIRST_GAIN  = 3'd0,
    REG_SECOND_GAIN = 3'd1,
    REG_THIRD_GAIN  = 3'd2,
    REG_PHASE_SCALE = 3'd3,
    REG_NYQUIST     = 3'd4
  } cfg_reg_t;

  localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
  localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
  localparam logic [16:0] ONE_Q16         = 17'd65536;

  // truncated atan(2^-i) in Q2.30 radians
  localparam logic [30:0] ATAN_Q30 [24] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158,
    31'd67021686,  31'd33543515,  31'd16775850,  31'd8388437,
    31'd4194282,   31'd2097149,   31'd1048575,   31'd524287,
    31'd262143,    31'd131071,    31'd65535,     31'd32767,
    31'd16383,     31'd8191,      31'd4095,      31'd2047,
    31'd1023,      31'd511,       31'd255,       31'd127
  };

  // quotient bits of the ratio divider, one divider cell each
  localparam int QW = 17;

  // cycles from split input to lp/hp output
  localparam int SPLIT_LAT = 9 + QW;

endpackage

### rtl/fbx_cordic_cell.sv
// ----------------------------------------------------------------------------
// fbx_cordic_cell
// One registered rotation-mode CORDIC iteration.
// ----------------------------------------------------------------------------
module fbx_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  fbx_pkg::meta_t meta_in,
  input  fbx_pkg::cval_t x_in,
  input  fbx_pkg::cval_t y_in,
  input  fbx_pkg::cval_t z_in,
  output fbx_pkg::meta_t meta_out,
  output fbx_pkg::cval_t x_out,
  output fbx_pkg::cval_t y_out,
  output fbx_pkg::cval_t z_out
);
  import fbx_pkg::*;

  cval_t dx;
  cval_t dy;
  cval_t ang;

  // floor shifts and angle of this step
  assign dx  = x_in >>> STEP;
  assign dy  = y_in >>> STEP;
  assign ang = $signed({{(XW-31){1'b0}}, ATAN_Q30[STEP]});

  // sideband
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_out <= '0;
    end else if (en) begin
      meta_out <= meta_in;
    end
  end

  // rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      if (z_in >= 0) begin
        x_out <= x_in - (y_in >>> STEP);
        y_out <= y_in + dx;
        z_out <= z_in - ang;
      end else begin
        x_out <= x_in + (y_in >>> STEP);
        y_out <= y_in - dx;
        z_out <= z_in + ang;
      end
    end
  end

  // dy kept for symmetry of the rotation terms
  logic unused_dy;
  assign unused_dy = ^dy;

endmodule

### rtl/fbx_div_cell.sv
// ----------------------------------------------------------------------------
// fbx_div_cell
// One registered restoring-division step producing quotient bit BIT.
// ----------------------------------------------------------------------------
module fbx_div_cell #(
  parameter int BIT = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rem_in,
  input  logic [46:0] den_in,
  input  logic [16:0] q_in,
  output logic [63:0] rem_out,
  output logic [46:0] den_out,
  output logic [16:0] q_out
);
  logic [63:0] dsh;
  logic        ge;

  // divisor aligned to this quotient bit
  assign dsh = {17'b0, den_in} << BIT;
  assign ge  = rem_in >= dsh;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? rem_in - dsh : rem_in;
      den_out <= den_in;
      q_out   <= q_in | (ge ? (17'd1 << BIT) : 17'd0);
    end
  end

endmodule

### rtl/fbx_split.sv
// ----------------------------------------------------------------------------
// fbx_split
// Lowpass and highpass ratios of one LR4 split from cos and sin.
// ----------------------------------------------------------------------------
module fbx_split (
  input  logic        clk,
  input  logic        en,
  input  logic [23:0] gain,
  input  logic [30:0] c,
  input  logic [30:0] s,
  output logic [16:0] lp,
  output logic [16:0] hp
);
  import fbx_pkg::*;

  // number of right shifts that brings v below 2^lim
  function automatic logic [5:0] shift_count(input logic [62:0] v, input int lim);
    int n;
    n = 0;
    for (int i = 0; i < 63; i++) begin
      if (v[i]) n = i + 1;
    end
    return (n > lim) ? 6'(n - lim) : 6'd0;
  endfunction

  logic [54:0] prod;
  logic [62:0] a1, b1, a2, b2;
  logic [5:0]  k1, k2, k3;
  logic [30:0] a3, b3, a6, b6;
  logic [61:0] a4, b4, a5, b5, a7, b7, a8, b8;
  logic [45:0] an, bn;
  logic [46:0] sum;

  logic [63:0] rem_l [QW+1];
  logic [63:0] rem_h [QW+1];
  logic [46:0] den_l [QW+1];
  logic [46:0] den_h [QW+1];
  logic [16:0] q_l   [QW+1];
  logic [16:0] q_h   [QW+1];
  logic        zero  [QW+1];

  assign prod = gain * c;
  assign an   = 46'(a8 >> k3);
  assign bn   = 46'(b8 >> k3);
  assign sum  = {1'b0, an} + {1'b0, bn};

  // scaling, squaring and renormalizing
  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= {8'b0, prod};
      b1 <= {16'b0, s, 16'b0};
      k1 <= shift_count(a1 | b1, 31);
      a2 <= a1;
      b2 <= b1;
      a3 <= 31'(a2 >> k1);
      b3 <= 31'(b2 >> k1);
      a4 <= a3 * a3;
      b4 <= b3 * b3;
      k2 <= shift_count({1'b0, a4 | b4}, 31);
      a5 <= a4;
      b5 <= b4;
      a6 <= 31'(a5 >> k2);
      b6 <= 31'(b5 >> k2);
      a7 <= a6 * a6;
      b7 <= b6 * b6;
      k3 <= shift_count({1'b0, a7 | b7}, 46);
      a8 <= a7;
      b8 <= b7;
      // rounded numerators and common divisor
      rem_l[0] <= {2'b0, an, 16'b0} + {18'b0, sum[46:1]};
      rem_h[0] <= {2'b0, bn, 16'b0} + {18'b0, sum[46:1]};
      den_l[0] <= sum;
      den_h[0] <= sum;
      zero[0]  <= (sum == '0);
    end
  end

  assign q_l[0] = '0;
  assign q_h[0] = '0;

  // one quotient bit per cell, most significant first
  for (genvar g = 0; g < QW; g++) begin : g_div
    fbx_div_cell #(.BIT(QW - 1 - g)) u_lp (
      .clk(clk), .en(en),
      .rem_in(rem_l[g]), .den_in(den_l[g]), .q_in(q_l[g]),
      .rem_out(rem_l[g+1]), .den_out(den_l[g+1]), .q_out(q_l[g+1])
    );
    fbx_div_cell #(.BIT(QW - 1 - g)) u_hp (
      .clk(clk), .en(en),
      .rem_in(rem_h[g]), .den_in(den_h[g]), .q_in(q_h[g]),
      .rem_out(rem_h[g+1]), .den_out(den_h[g+1]), .q_out(q_h[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        zero[g+1] <= zero[g];
      end
    end
  end

  // both fourth powers zero counts as fully lowpass
  assign lp = zero[QW] ? ONE_Q16 : q_l[QW];
  assign hp = zero[QW] ? 17'd0 : q_h[QW];

  logic unused_tail;
  assign unused_tail = ^{rem_l[QW], rem_h[QW], den_l[QW], den_h[QW]};

endmodule

### rtl/four_band_crossover_magnitude.sv
// ----------------------------------------------------------------------------
// four_band_crossover_magnitude
// Magnitude of the four bands of a three-split LR4 crossover per frequency.
// ----------------------------------------------------------------------------
// Fully pipelined: one frequency item is taken every cycle while the result
// register can take an item, and each yields one result item through the
// stages (angle 2, CORDIC one cell per step, clamp 1, split normalize 9, ratio
// divider 17 cells, band products 2, output register 1). The whole pipeline
// holds while the result register is full and not taken. Configuration writes
// are taken at once and must occur while no item is in flight.
// ----------------------------------------------------------------------------
module four_band_crossover_magnitude #(
  parameter int CORDIC_STEPS = 18
) (
  input  logic        clk,
  input  logic        rst,
  // input item: tdata = frequency[20:0], zero pad; tlast = is_last
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        s_tlast,
  // result item: tdata = band_one_mag, band_two_mag, band_three_mag,
  // band_four_mag (17 bits each), zero pad; tuser = in_range;
  // tlast = end_of_vector
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data
);
  import fbx_pkg::*;

  logic        adv;
  logic [23:0] gain1, gain2, gain3;
  logic [24:0] phase_scale;
  logic [20:0] nyquist;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      gain1       <= 24'd1287;
      gain2       <= 24'd13036;
      gain3       <= 24'd37837;
      phase_scale <= 25'd2863312;
      nyquist     <= 21'd384000;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FIRST_GAIN:  gain1       <= cfg_data[23:0];
        REG_SECOND_GAIN: gain2       <= cfg_data[23:0];
        REG_THIRD_GAIN:  gain3       <= cfg_data[23:0];
        REG_PHASE_SCALE: phase_scale <= cfg_data;
        REG_NYQUIST:     nyquist     <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the result register can take a new item
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // angle stage one: frequency times phase scale
  meta_t       meta1, meta2;
  logic [45:0] p1;
  always_ff @(posedge clk) begin
    if (rst) begin
      meta1 <= '0;
    end else if (adv) begin
      meta1.valid    <= s_tvalid;
      meta1.last     <= s_tlast;
      meta1.in_range <= s_tdata[20:0] <= nyquist;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= s_tdata[20:0] * phase_scale;
    end
  end

  // angle stage two: saturate quarter turn, scale to Q2.30 radians
  logic [16:0] theta;
  logic [47:0] zprod;
  cval_t       z0;
  assign theta = (p1[45:24] > 22'd65536) ? ONE_Q16 : p1[40:24];
  assign zprod = theta * HALF_PI_Q30 + 48'd32768;
  always_ff @(posedge clk) begin
    if (rst) begin
      meta2 <= '0;
    end else if (adv) begin
      meta2 <= meta1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      z0 <= $signed({{(XW-32){1'b0}}, zprod[47:16]});
    end
  end

  // cordic chain
  meta_t cmeta [CORDIC_STEPS+1];
  cval_t cx    [CORDIC_STEPS+1];
  cval_t cy    [CORDIC_STEPS+1];
  cval_t cz    [CORDIC_STEPS+1];
  assign cmeta[0] = meta2;
  assign cx[0]    = $signed({{(XW-30){1'b0}}, CORDIC_GAIN_Q30});
  assign cy[0]    = '0;
  assign cz[0]    = z0;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    fbx_cordic_cell #(.STEP(g)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .meta_in(cmeta[g]), .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]),
      .meta_out(cmeta[g+1]), .x_out(cx[g+1]), .y_out(cy[g+1]), .z_out(cz[g+1])
    );
  end

  // clamp cos and sin to [0, 1]
  localparam cval_t ONE_Q30 = cval_t'(34'sd1073741824);
  cval_t       xe, ye;
  logic [30:0] cosv, sinv;
  meta_t       meta3;
  assign xe = cx[CORDIC_STEPS];
  assign ye = cy[CORDIC_STEPS];
  always_ff @(posedge clk) begin
    if (rst) begin
      meta3 <= '0;
    end else if (adv) begin
      meta3 <= cmeta[CORDIC_STEPS];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      cosv <= (xe < 0) ? 31'd0 : (xe > ONE_Q30) ? 31'(ONE_Q30) : 31'(xe);
      sinv <= (ye < 0) ? 31'd0 : (ye > ONE_Q30) ? 31'(ONE_Q30) : 31'(ye);
    end
  end

  // three splits in parallel
  logic [16:0] lp1, hp1, lp2, hp2, lp3, hp3;
  fbx_split u_split1 (.clk(clk), .en(adv), .gain(gain1), .c(cosv), .s(sinv),
                      .lp(lp1), .hp(hp1));
  fbx_split u_split2 (.clk(clk), .en(adv), .gain(gain2), .c(cosv), .s(sinv),
                      .lp(lp2), .hp(hp2));
  fbx_split u_split3 (.clk(clk), .en(adv), .gain(gain3), .c(cosv), .s(sinv),
                      .lp(lp3), .hp(hp3));

  // sideband alongside the splits
  meta_t smeta [SPLIT_LAT+1];
  assign smeta[0] = meta3;
  for (genvar g = 0; g < SPLIT_LAT; g++) begin : g_smeta
    always_ff @(posedge clk) begin
      if (rst) begin
        smeta[g+1] <= '0;
      end else if (adv) begin
        smeta[g+1] <= smeta[g];
      end
    end
  end

  // band products, two multiplies deep
  meta_t       meta4, meta5;
  logic [33:0] pll, phl, phh;
  logic [16:0] lp3d, hp3d;
  logic [50:0] b1, b2, b3, b4;
  always_ff @(posedge clk) begin
    if (rst) begin
      meta4 <= '0;
      meta5 <= '0;
    end else if (adv) begin
      meta4 <= smeta[SPLIT_LAT];
      meta5 <= meta4;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pll  <= lp1 * lp2;
      phl  <= hp1 * lp2;
      phh  <= hp1 * hp2;
      lp3d <= lp3;
      hp3d <= hp3;
      b1   <= pll * lp3d;
      b2   <= phl * lp3d;
      b3   <= phh * lp3d;
      b4   <= phh * hp3d;
    end
  end

  // rounding and result register
  logic [51:0] r1, r2, r3, r4;
  logic [16:0] m1, m2, m3, m4;
  assign r1 = {1'b0, b1} + 52'h0_0000_8000_0000;
  assign r2 = {1'b0, b2} + 52'h0_0000_8000_0000;
  assign r3 = {1'b0, b3} + 52'h0_0000_8000_0000;
  assign r4 = {1'b0, b4} + 52'h0_0000_8000_0000;
  assign m1 = meta5.in_range ? r1[48:32] : 17'd0;
  assign m2 = meta5.in_range ? r2[48:32] : 17'd0;
  assign m3 = meta5.in_range ? r3[48:32] : 17'd0;
  assign m4 = meta5.in_range ? r4[48:32] : 17'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= meta5.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {4'b0, m4, m3, m2, m1};
      m_tuser <= meta5.in_range;
      m_tlast <= meta5.last;
    end
  end

  logic unused_cz;
  assign unused_cz = ^{cz[CORDIC_STEPS], r1[51:49], r2[51:49], r3[51:49], r4[51:49],
                       s_tdata[23:21], r1[31:0], r2[31:0], r3[31:0], r4[31:0]};

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-band crossover magnitude pipeline: drives
// frequency items, predicts every band magnitude in fixed point and compares
// each result item in order, across register settings and flow-control modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fbx_pkg::*;

  localparam int STEPS = 18;
  localparam int PIPE_LAT = STEPS + 33;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [16:0] band_one;
    logic [16:0] band_two;
    logic [16:0] band_three;
    logic [16:0] band_four;
    logic        in_range;
    logic        end_of_vector;
  } bands_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [71:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [24:0] cfg_data = '0;

  // local copy of the register file
  logic [23:0] gain_q16 [3];
  logic [24:0] phase_scale_r;
  logic [20:0] nyquist_r;

  bands_t expected_bands [$];
  int     error_count = 0;
  int     cycle_count = 0;
  int     idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
  int     hold_request = 0;
  int     hold_left = 0;

  four_band_crossover_magnitude #(.CORDIC_STEPS(STEPS)) dut (.*);

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // shift both operands down until each is below 2^bits
  function automatic void shift_pair(inout longint unsigned a, inout longint unsigned b,
                                     input int bits);
    longint unsigned lim;
    lim = 64'd1 << bits;
    while (a >= lim || b >= lim) begin
      a = a >> 1;
      b = b >> 1;
    end
  endfunction

  function automatic void split_lp_hp(input longint unsigned gain, input longint unsigned c,
                                      input longint unsigned s,
                                      output longint unsigned lp, output longint unsigned hp);
    longint unsigned a, b, sum;
    a = gain * c;
    b = s << 16;
    shift_pair(a, b, 31);
    a = a * a;
    b = b * b;
    shift_pair(a, b, 31);
    a = a * a;
    b = b * b;
    shift_pair(a, b, 46);
    sum = a + b;
    if (sum == 0) begin
      lp = 65536;
      hp = 0;
    end else begin
      lp = ((a << 16) + sum / 2) / sum;
      hp = ((b << 16) + sum / 2) / sum;
    end
  endfunction

  function automatic logic [16:0] triple_q16(longint unsigned p, longint unsigned q,
                                             longint unsigned r);
    longint unsigned prod;
    prod = (p * q * r + (64'd1 << 31)) >> 32;
    return prod[16:0];
  endfunction

  function automatic bands_t predict_bands(logic [20:0] freq, logic last);
    bands_t res;
    longint unsigned theta;
    longint x, y, z, dx, dy;
    longint unsigned lp [3], hp [3];
    res = '0;
    res.end_of_vector = last;
    if (freq > nyquist_r) return res;
    theta = (longint'(freq) * longint'(phase_scale_r)) >> 24;
    if (theta > 65536) theta = 65536;
    z = longint'((theta * longint'(HALF_PI_Q30) + 32768) >> 16);
    x = longint'(CORDIC_GAIN_Q30);
    y = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_Q30[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_Q30[i]);
      end
    end
    if (x < 0) x = 0;
    if (x > (64'sd1 << 30)) x = 64'sd1 << 30;
    if (y < 0) y = 0;
    if (y > (64'sd1 << 30)) y = 64'sd1 << 30;
    for (int k = 0; k < 3; k++)
      split_lp_hp(gain_q16[k], x, y, lp[k], hp[k]);
    res.band_one   = triple_q16(lp[0], lp[1], lp[2]);
    res.band_two   = triple_q16(hp[0], lp[1], lp[2]);
    res.band_three = triple_q16(hp[0], hp[1], lp[2]);
    res.band_four  = triple_q16(hp[0], hp[1], hp[2]);
    res.in_range   = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    bands_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bands.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = expected_bands.pop_front();
        if (m_tdata[16:0] !== want.band_one)
          report_mismatch("band_one_mag", m_tdata[16:0], want.band_one);
        if (m_tdata[33:17] !== want.band_two)
          report_mismatch("band_two_mag", m_tdata[33:17], want.band_two);
        if (m_tdata[50:34] !== want.band_three)
          report_mismatch("band_three_mag", m_tdata[50:34], want.band_three);
        if (m_tdata[67:51] !== want.band_four)
          report_mismatch("band_four_mag", m_tdata[67:51], want.band_four);
        if (m_tdata[71:68] !== 4'd0)
          report_mismatch("tdata pad", m_tdata[71:68], 0);
        if (m_tuser !== want.in_range)
          report_mismatch("in_range", m_tuser, want.in_range);
        if (m_tlast !== want.end_of_vector)
          report_mismatch("end_of_vector", m_tlast, want.end_of_vector);
      end
    end
  end

  // receiver flow control, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (idle_mode == 2) begin
      m_tready <= ($urandom_range(99) >= 71);
    end else if (idle_mode == 3) begin
      m_tready <= ($urandom_range(99) >= 29);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_frequency(logic [20:0] freq, logic last);
    int idle_pct;
    idle_pct = (idle_mode == 1) ? 71 : (idle_mode == 3) ? 29 : 0;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {3'b000, freq};
    s_tlast  = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_bands.push_back(predict_bands(freq, last));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (expected_bands.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(cfg_reg_t idx, logic [24:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FIRST_GAIN:  gain_q16[0]   = value[23:0];
      REG_SECOND_GAIN: gain_q16[1]   = value[23:0];
      REG_THIRD_GAIN:  gain_q16[2]   = value[23:0];
      REG_PHASE_SCALE: phase_scale_r = value;
      REG_NYQUIST:     nyquist_r     = value[20:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_settings(logic [23:0] g1, logic [23:0] g2, logic [23:0] g3,
                               logic [24:0] ps, logic [20:0] nyq);
    wait_drained();
    write_register(REG_FIRST_GAIN, {1'b0, g1});
    write_register(REG_SECOND_GAIN, {1'b0, g2});
    write_register(REG_THIRD_GAIN, {1'b0, g3});
    write_register(REG_PHASE_SCALE, ps);
    write_register(REG_NYQUIST, {4'b0, nyq});
  endtask

  function automatic logic [20:0] pick_frequency();
    int roll;
    roll = $urandom_range(99);
    if (roll < 75) return 21'($urandom_range(nyquist_r));
    if (roll < 85) return 21'($urandom_range(2097151));
    if (roll < 92) return (nyquist_r == 21'h1fffff) ? nyquist_r : nyquist_r + 21'd1;
    return 21'($urandom_range(15));
  endfunction

  // field extremes, Nyquist edge, zero gain at zero angle, angle saturation
  task automatic test_directed();
    idle_mode = 0;
    send_frequency(21'd0, 1'b0);
    send_frequency(21'd1, 1'b0);
    send_frequency(21'd16000, 1'b0);
    send_frequency(21'd32000, 1'b0);
    send_frequency(21'd160000, 1'b0);
    send_frequency(21'd384000, 1'b0);
    send_frequency(21'd384001, 1'b1);
    send_frequency(21'h1fffff, 1'b1);
    send_frequency(21'h0aaaaa, 1'b0);
    send_frequency(21'h155555, 1'b1);
    load_settings(24'd0, 24'd0, 24'd0, 25'd2863312, 21'd384000);
    send_frequency(21'd0, 1'b0);
    send_frequency(21'd100, 1'b1);
    load_settings(24'hffffff, 24'hffffff, 24'hffffff, 25'h1ffffff, 21'h1fffff);
    send_frequency(21'd0, 1'b0);
    send_frequency(21'd1, 1'b0);
    send_frequency(21'd600000, 1'b0);
    send_frequency(21'h1fffff, 1'b1);
    load_settings(24'd1287, 24'd13036, 24'd37837, 25'd0, 21'd0);
    send_frequency(21'd0, 1'b0);
    send_frequency(21'd1, 1'b1);
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++)
      send_frequency(pick_frequency(), $urandom_range(7) == 0);
  endtask

  // random settings across all flow-control modes
  task automatic test_random_settings();
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0)
        load_settings(24'd1287, 24'd13036, 24'd37837, 25'd2863312, 21'd384000);
      else
        load_settings(24'($urandom_range(24'hffffff) >> $urandom_range(23)),
                      24'($urandom_range(24'hffffff) >> $urandom_range(23)),
                      24'($urandom_range(24'hffffff) >> $urandom_range(23)),
                      25'($urandom_range(25'h1ffffff) >> $urandom_range(8)),
                      21'($urandom_range(21'h1fffff)));
      idle_mode = phase % 4;
      run_random(90);
    end
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    load_settings(24'd1287, 24'd13036, 24'd37837, 25'd2863312, 21'd384000);
    idle_mode = 0;
    hold_request = 300;
    run_random(100);
  endtask

  // sender waits for a full drain mid-stream
  task automatic test_drain_pause();
    idle_mode = 3;
    run_random(20);
    wait_drained();
    run_random(10);
  endtask

  initial begin
    gain_q16[0] = 24'd1287;
    gain_q16[1] = 24'd13036;
    gain_q16[2] = 24'd37837;
    phase_scale_r = 25'd2863312;
    nyquist_r = 21'd384000;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_random_settings();
    test_backpressure();
    test_drain_pause();
    wait_drained();
    repeat (PIPE_LAT + 20) @(negedge clk);
    if (error_count == 0 && expected_bands.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
